@@ hdl/bte_pkg.sv @@
// ---------------------------------------------------------------------------
// bte_pkg: shared types for the ban table with expiry
// Beat payloads, queued commands, table entries and front/back status.
// ---------------------------------------------------------------------------
package bte_pkg;

	localparam logic [1:0] FUNC_BAN   = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] address;
		logic [7:0]  ban_seconds;
	} in_t;

	typedef struct packed {
		logic       is_banned;
		logic [7:0] seconds_left;
		logic       table_full;
		logic       table_changed;
	} out_t;

	typedef enum logic [1:0] {
		OP_BAN   = 2'd0,
		OP_TICK  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] address;
		logic [7:0]  ban_seconds;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] address;
		logic [7:0]  seconds;
	} ent_t;

	// back -> front
	typedef struct packed {
		logic clearing;
		logic pop;
	} back_stat_t;

endpackage

@@ hdl/ban_table_with_expiry_top.sv @@
// ---------------------------------------------------------------------------
// ban_table_with_expiry_top: IPv4 ban table with per-entry seconds aging
// Ban, tick and query commands against a table of ENTRIES addresses.
// ---------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the beat is taken at
// that edge. Each item yields exactly one result, shown on result for a
// single cycle while strobe is high; the receiver cannot stall it, so sample
// it then. Items are served in order, one at a time. Every item except the
// unused function code walks the whole table through the single read port
// of the entry memory. The engine picks up the command in its idle state,
// scans the table and finishes in a done state that registers the result
// and raises strobe; the unused code skips the scan. A two-deep queue takes
// up to two further items while one is in service; busy rises when it is
// full. After reset the engine clears the table, one entry per cycle, and
// holds busy high meanwhile.
// ---------------------------------------------------------------------------
module ban_table_with_expiry_top #(
	parameter int ENTRIES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bte_pkg::in_t  item,
	output logic          strobe,
	output bte_pkg::out_t result
);
	import bte_pkg::*;

	back_stat_t stat;
	logic       cmd_valid;
	cmd_t       cmd;

	// front: decode beats, queue commands until the engine is free
	bte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.stat     (stat),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	// back: scan the table, update entries, drive the result beat
	bte_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.stat     (stat),
		.strobe   (strobe),
		.result   (result)
	);

endmodule

@@ hdl/bte_front.sv @@
// ---------------------------------------------------------------------------
// bte_front: command intake
// Decode incoming beats into commands and hold them in a two-deep queue.
// ---------------------------------------------------------------------------
module bte_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bte_pkg::in_t       item,
	input  bte_pkg::back_stat_t stat,
	output logic               cmd_valid,
	output bte_pkg::cmd_t      cmd
);
	import bte_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       dec;

	always_comb begin
		dec.address     = item.address;
		dec.ban_seconds = item.ban_seconds;
		case (item.func)
			FUNC_BAN:   dec.op = OP_BAN;
			FUNC_TICK:  dec.op = OP_TICK;
			FUNC_QUERY: dec.op = OP_QUERY;
			default:    dec.op = OP_NOP;
		endcase
	end

	assign busy      = (count_q == 2'd2) || stat.clearing;
	assign push      = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = stat.pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/bte_back.sv @@
// ---------------------------------------------------------------------------
// bte_back: table engine
// Scan the entry memory once per ban, tick or query command and apply it.
// ---------------------------------------------------------------------------
module bte_back #(
	parameter int ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  bte_pkg::cmd_t       cmd,
	output bte_pkg::back_stat_t stat,
	output logic                strobe,
	output bte_pkg::out_t       result
);
	import bte_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	ent_t mem [ENTRIES];

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             cmd_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	ent_t             rdata_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [7:0]       hit_secs_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             changed_q;
	logic             strobe_q;
	out_t             result_q;

	logic             we;
	logic [IDX_W-1:0] wa;
	ent_t             wd;
	logic             match;
	logic [8:0]       sum;
	logic [7:0]       sat;
	out_t             res_d;

	assign match = rdata_s1.valid && (rdata_s1.address == cmd_q.address);
	assign sum   = {1'b0, hit_secs_q} + {1'b0, cmd_q.ban_seconds};
	assign sat   = sum[8] ? 8'hFF : sum[7:0];

	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.pop      = (state_q == ST_IDLE) && cmd_valid;
	assign strobe        = strobe_q;
	assign result        = result_q;

	// write port and result of the finishing cycle
	always_comb begin
		we    = 1'b0;
		wa    = idx_s1;
		wd    = rdata_s1;
		res_d = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = cnt_q[IDX_W-1:0];
				wd = '0;
			end
			ST_SCAN: begin
				if (vld_s1 && (cmd_q.op == OP_TICK) && rdata_s1.valid) begin
					we = 1'b1;
					wa = idx_s1;
					if (rdata_s1.seconds != 8'd0) begin
						wd.seconds = rdata_s1.seconds - 8'd1;
					end else begin
						wd.valid = 1'b0;
					end
				end
			end
			ST_DONE: begin
				case (cmd_q.op)
					OP_BAN: begin
						if (hit_q) begin
							we                 = 1'b1;
							wa                 = hit_idx_q;
							wd.valid           = 1'b1;
							wd.address         = cmd_q.address;
							wd.seconds         = sat;
							res_d.is_banned    = 1'b1;
							res_d.seconds_left = sat;
						end else if (free_q) begin
							we                  = 1'b1;
							wa                  = free_idx_q;
							wd.valid            = 1'b1;
							wd.address          = cmd_q.address;
							wd.seconds          = cmd_q.ban_seconds;
							res_d.is_banned     = 1'b1;
							res_d.seconds_left  = cmd_q.ban_seconds;
							res_d.table_changed = 1'b1;
						end else begin
							res_d.table_full = 1'b1;
						end
					end
					OP_TICK: res_d.table_changed = changed_q;
					OP_QUERY: begin
						res_d.is_banned    = hit_q;
						res_d.seconds_left = hit_q ? hit_secs_q : 8'd0;
					end
					default: res_d = '0;
				endcase
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_s1 <= mem[cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd_valid) begin
			cmd_q <= cmd;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (state_q == ST_DONE) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_secs_q <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			changed_q  <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					cnt_q     <= '0;
					vld_s1    <= 1'b0;
					hit_q     <= 1'b0;
					free_q    <= 1'b0;
					changed_q <= 1'b0;
					if (cmd_valid) begin
						state_q <= (cmd.op == OP_NOP) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, evaluate the entry read last cycle
					if (cnt_q != CNT_END) begin
						cnt_q  <= cnt_q + 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (match && !hit_q) begin
							hit_q      <= 1'b1;
							hit_idx_q  <= idx_s1;
							hit_secs_q <= rdata_s1.seconds;
						end
						if (!rdata_s1.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if ((cmd_q.op == OP_TICK) && rdata_s1.valid &&
						    (rdata_s1.seconds == 8'd0)) begin
							changed_q <= 1'b1;
						end
						if (idx_s1 == IDX_LAST) begin
							vld_s1  <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					strobe_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/bte_checker.sv @@
// ---------------------------------------------------------------------------
// bte_checker: port-level checks for the ban table
// Result consistency and strobe spacing seen at the top-level ports.
// ---------------------------------------------------------------------------
module bte_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          strobe,
	input bte_pkg::out_t result
);
	import bte_pkg::*;

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(result.table_full && result.is_banned))
		else $error("dropped ban reported as banned");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.table_full) |->
			(result.seconds_left == 8'd0) && !result.table_changed)
		else $error("dropped ban carries seconds or change flag");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.is_banned) |-> (result.seconds_left == 8'd0))
		else $error("absent address with nonzero seconds");

	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result beats in consecutive cycles");

endmodule

bind ban_table_with_expiry_top bte_checker u_bte_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.strobe(strobe),
	.result(result)
);

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the ban table with expiry
// Drives ban, tick, query and unused-code beats through the start/busy
// handshake, mirrors the table in a local model and checks every strobed
// result field by field against the oldest predicted result.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bte_pkg::*;

	localparam int ENTRIES       = 64;
	localparam int ADDR_POOL     = 80;   // more than ENTRIES so the table can fill
	localparam int MAX_REPORTS   = 10;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 2 * (ENTRIES + 8);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	in_t  item   = '0;
	logic busy;
	logic strobe;
	out_t result;

	ban_table_with_expiry_top #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always #5ns clk = ~clk;

	// -----------------------------------------------------------------------
	// Mirror of the ban table: valid flag, address and seconds per entry
	// -----------------------------------------------------------------------
	logic        ban_valid [ENTRIES];
	logic [31:0] ban_addr  [ENTRIES];
	logic [7:0]  ban_count [ENTRIES];

	out_t        expected_results [$];
	logic [31:0] address_pool [ADDR_POOL];
	int          fail_count = 0;
	int          burst_left = 0;
	bit          gaps_on    = 1'b1;

	// Advance the mirror by one command and return the result it must give.
	function automatic out_t predict_ban_table(in_t it);
		out_t       r;
		int         hit;
		int         free_slot;
		logic [8:0] sum;
		r = '0;
		hit = -1;
		free_slot = -1;
		case (op_t'(it.func))
			OP_BAN: begin
				// A lookup hit wins over a free slot; otherwise take the lowest free one.
				for (int i = 0; i < ENTRIES; i++) begin
					if (ban_valid[i] && ban_addr[i] == it.address && hit < 0)
						hit = i;
					if (!ban_valid[i] && free_slot < 0)
						free_slot = i;
				end
				if (hit >= 0) begin
					sum = {1'b0, ban_count[hit]} + {1'b0, it.ban_seconds};
					if (sum > 9'd255)
						sum = 9'd255;
					ban_count[hit]  = sum[7:0];
					r.is_banned     = 1'b1;
					r.seconds_left  = sum[7:0];
				end else if (free_slot >= 0) begin
					ban_valid[free_slot] = 1'b1;
					ban_addr[free_slot]  = it.address;
					ban_count[free_slot] = it.ban_seconds;
					r.is_banned          = 1'b1;
					r.seconds_left       = it.ban_seconds;
					r.table_changed      = 1'b1;
				end else begin
					r.table_full = 1'b1;
				end
			end
			OP_TICK: begin
				// Age every live entry; drop the ones already at zero.
				for (int i = 0; i < ENTRIES; i++) begin
					if (ban_valid[i]) begin
						if (ban_count[i] != 8'd0) begin
							ban_count[i] = ban_count[i] - 8'd1;
						end else begin
							ban_valid[i]    = 1'b0;
							r.table_changed = 1'b1;
						end
					end
				end
			end
			OP_QUERY: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (ban_valid[i] && ban_addr[i] == it.address && !r.is_banned) begin
						r.is_banned    = 1'b1;
						r.seconds_left = ban_count[i];
					end
				end
			end
			default: begin
				// Unused code: table untouched, all-zero result.
			end
		endcase
		return r;
	endfunction

	function automatic in_t random_item();
		in_t it;
		it.func        = 2'($urandom);
		it.address     = $urandom;
		it.ban_seconds = 8'($urandom);
		return it;
	endfunction

	function automatic in_t make_item(logic [1:0] f, logic [31:0] a, logic [7:0] s);
		in_t it;
		it.func        = f;
		it.address     = a;
		it.ban_seconds = s;
		return it;
	endfunction

	// Mostly pool addresses so bans repeat and queries hit; some fresh ones.
	function automatic logic [31:0] pick_address();
		if ($urandom_range(0, 3) != 0)
			return address_pool[$urandom_range(0, ADDR_POOL - 1)];
		return $urandom;
	endfunction

	// Mostly short bans so entries expire within a few ticks; some long ones
	// and some near the top to hit saturation.
	function automatic logic [7:0] pick_seconds();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 8'($urandom_range(0, 4));
		if (roll < 8)
			return 8'($urandom);
		if (roll == 8)
			return 8'd255;
		return 8'($urandom_range(240, 255));
	endfunction

	// Profile 0 balanced, 1 filling (mostly bans), 2 aging (many ticks).
	function automatic in_t random_command(int profile);
		int ban_cut   [3] = '{40, 75, 25};
		int tick_cut  [3] = '{65, 78, 60};
		int query_cut [3] = '{95, 97, 95};
		in_t it;
		int  roll;
		it   = random_item();
		roll = $urandom_range(0, 99);
		if (roll < ban_cut[profile]) begin
			it.func        = FUNC_BAN;
			it.address     = pick_address();
			it.ban_seconds = pick_seconds();
		end else if (roll < tick_cut[profile]) begin
			it.func = FUNC_TICK;
		end else if (roll < query_cut[profile]) begin
			it.func    = FUNC_QUERY;
			it.address = pick_address();
		end else begin
			it.func = OP_NOP;
		end
		return it;
	endfunction

	// -----------------------------------------------------------------------
	// Sender: drive at the falling edge, count a beat at the rising edge
	// where start is high and busy is low.
	// -----------------------------------------------------------------------
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			item  <= random_item();   // noise on the bus must be ignored
		end
	endtask

	task automatic send_item(in_t it);
		// Open a new burst after a random gap; a zero gap keeps start high.
		if (gaps_on && burst_left == 0) begin
			idle_cycles($urandom_range(0, 12));
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		// Hold the beat until an edge sees busy low.
		do
			@(posedge clk);
		while (busy);
		expected_results = {expected_results, predict_ban_table(it)};
	endtask

	// Drop start and hold off until every predicted result has come back or the drain limit runs out.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		idle_cycles(1);
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// -----------------------------------------------------------------------
	// Result checker: one strobed beat against the oldest prediction
	// -----------------------------------------------------------------------
	task automatic report_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want)
			report_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				report_failure($sformatf("result beat with none pending: %h", result));
			end else begin
				want = expected_results.pop_front();
				check_field("is_banned",     8'(want.is_banned),     8'(result.is_banned));
				check_field("seconds_left",  want.seconds_left,      result.seconds_left);
				check_field("table_full",    8'(want.table_full),    8'(result.table_full));
				check_field("table_changed", 8'(want.table_changed), 8'(result.table_changed));
			end
		end
	end

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Empty table: misses at both address extremes, a tick that removes
	// nothing, and the unused code with every field bit set.
	task automatic test_empty_table();
		send_item(make_item(FUNC_QUERY, 32'h0000_0000, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'hFFFF_FFFF, 8'hFF));
		send_item(make_item(FUNC_TICK,  32'hFFFF_FFFF, 8'hFF));
		send_item(make_item(OP_NOP,     32'hFFFF_FFFF, 8'hFF));
	endtask

	// New bans, extension with saturation, extension by zero.
	task automatic test_ban_and_extend();
		send_item(make_item(FUNC_BAN,   32'h0000_0000, 8'd0));
		send_item(make_item(FUNC_BAN,   32'hFFFF_FFFF, 8'd255));
		send_item(make_item(FUNC_BAN,   32'hFFFF_FFFF, 8'd1));
		send_item(make_item(FUNC_BAN,   32'h1234_5678, 8'd200));
		send_item(make_item(FUNC_BAN,   32'h1234_5678, 8'd100));
		send_item(make_item(FUNC_BAN,   32'h8000_0001, 8'd1));
		send_item(make_item(FUNC_BAN,   32'h0000_0000, 8'd0));
		send_item(make_item(FUNC_QUERY, 32'hFFFF_FFFF, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'h1234_5678, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'h8000_0000, 8'h00));
	endtask

	// Zero-second entry goes on the first tick, one-second entry on the
	// second; check removal flags and the queries in between.
	task automatic test_tick_expiry();
		send_item(make_item(FUNC_TICK,  32'h0000_0000, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'h0000_0000, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'h8000_0001, 8'h00));
		send_item(make_item(FUNC_TICK,  32'h0000_0000, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'h8000_0001, 8'h00));
		send_item(make_item(FUNC_TICK,  32'h0000_0000, 8'h00));
		send_item(make_item(OP_NOP,     32'h0000_0000, 8'h00));
		send_item(make_item(FUNC_QUERY, 32'hFFFF_FFFF, 8'h00));
	endtask

	// Fill the table with fresh addresses until bans are dropped, extend and
	// query while full, then age it down with ticks.
	task automatic test_table_overflow();
		logic [31:0] fresh [72];
		for (int i = 0; i < 72; i++) begin
			fresh[i] = $urandom;
			send_item(make_item(FUNC_BAN, fresh[i], 8'($urandom_range(0, 20))));
		end
		for (int i = 0; i < 8; i++) begin
			send_item(make_item(FUNC_BAN, fresh[$urandom_range(0, 71)], pick_seconds()));
			send_item(make_item(FUNC_QUERY, fresh[$urandom_range(0, 71)], 8'($urandom)));
		end
		repeat (24)
			send_item(make_item(FUNC_TICK, $urandom, 8'($urandom)));
	endtask

	// Episodes of random length, each with its own command mix and with
	// sender gaps switched on or off.
	task automatic test_random_traffic(int total);
		int sent;
		int profile;
		int len;
		sent = 0;
		while (sent < total) begin
			profile = $urandom_range(0, 2);
			len     = $urandom_range(20, 120);
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < len && sent < total; k++) begin
				send_item(random_command(profile));
				sent++;
			end
		end
		gaps_on = 1'b1;
	endtask

	// -----------------------------------------------------------------------
	// Sequence
	// -----------------------------------------------------------------------
	initial begin
		for (int i = 0; i < ADDR_POOL; i++)
			address_pool[i] = $urandom;
		address_pool[0] = 32'h0000_0000;
		address_pool[1] = 32'hFFFF_FFFF;
		for (int i = 0; i < ENTRIES; i++) begin
			ban_valid[i] = 1'b0;
			ban_addr[i]  = '0;
			ban_count[i] = '0;
		end

		// Hold reset, then release it on a falling edge.
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_ban_and_extend();
		wait_for_results();
		test_tick_expiry();
		wait_for_results();
		test_table_overflow();
		wait_for_results();
		test_random_traffic(1130);

		// Drain, then let any stray beat show up before judging.
		wait_for_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (expected_results.size() != 0)
			report_failure($sformatf("%0d results never arrived", expected_results.size()));

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/bte_pkg.sv
hdl/bte_front.sv
hdl/bte_back.sv
hdl/ban_table_with_expiry_top.sv
hdl/bte_checker.sv
test/tb_top.sv
